[src/polar_frozen_set_construction_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the polar frozen set construction block
// Shared property forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef POLAR_FROZEN_SET_CONSTRUCTION_ASSERT_SVH
`define POLAR_FROZEN_SET_CONSTRUCTION_ASSERT_SVH

// Same-cycle implication.
`define PFSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfsc assertion failed");

// Next-cycle implication.
`define PFSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfsc assertion failed");

`endif

[src/pfsc_pkg.sv]
// ----------------------------------------------------------------------------
// pfsc_pkg
// Constants, types and state codes of the polar frozen set construction.
// ----------------------------------------------------------------------------
package pfsc_pkg;

  localparam int MAX_LENGTH   = 1024;
  localparam int LOG_HARD_CAP = 10;

  function automatic int floor_log2_cap(int len);
    int lg;
    lg = 0;
    for (int i = 0; i < LOG_HARD_CAP; i++) begin
      if ((lg < LOG_HARD_CAP) && ((2 << lg) <= len)) begin
        lg = lg + 1;
      end
    end
    return lg;
  endfunction

  localparam int LOG_CAP   = floor_log2_cap(MAX_LENGTH);
  localparam int MEM_DEPTH = 1 << LOG_CAP;
  localparam int MEM_AW    = (LOG_CAP < 1) ? 1 : LOG_CAP;

  localparam int Z_W     = 32;
  localparam int LG_W    = 4;
  localparam int K_W     = 11;
  localparam int IDX_W   = 11;
  localparam int WORD_W  = 64;
  localparam int WIDX_W  = 4;
  localparam int NCELL   = 64;
  localparam int CELL_AW = 6;
  localparam int DRAIN_W = 7;
  localparam int DRAIN_LAST = NCELL;

  typedef struct packed {
    logic [Z_W-1:0]   z;
    logic [IDX_W-1:0] idx;
  } pfsc_own_t;

  typedef struct packed {
    logic             valid;
    logic [Z_W-1:0]   z;
    logic [IDX_W-1:0] idx;
  } pfsc_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_BF_RD,
    S_BF_MUL,
    S_BF_WLO,
    S_BF_WHI,
    S_LOAD,
    S_CMP,
    S_DRAIN
  } pfsc_state_t;

endpackage

[src/pfsc_in_if.sv]
// ----------------------------------------------------------------------------
// pfsc_in_if
// Request channel: erasure probability, length exponent and frozen count.
// ----------------------------------------------------------------------------
interface pfsc_in_if;
  import pfsc_pkg::*;

  logic             valid;
  logic             ready;
  logic [Z_W-1:0]   erasure_prob;
  logic [LG_W-1:0]  log_length;
  logic [K_W-1:0]   frozen_count;

  modport source (output valid, erasure_prob, log_length, frozen_count, input ready);
  modport sink   (input valid, erasure_prob, log_length, frozen_count, output ready);
endinterface

[src/pfsc_out_if.sv]
// ----------------------------------------------------------------------------
// pfsc_out_if
// Result channel: one 64-bit slice of the frozen mask per word.
// ----------------------------------------------------------------------------
interface pfsc_out_if;
  import pfsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WIDX_W-1:0] word_index;
  logic [WORD_W-1:0] frozen_mask;
  logic              last_word;

  modport source (output valid, word_index, frozen_mask, last_word, input ready);
  modport sink   (input valid, word_index, frozen_mask, last_word, output ready);
endinterface

[src/pfsc_butterfly.sv]
// ----------------------------------------------------------------------------
// pfsc_butterfly
// One Bhattacharyya butterfly: registered square, then 2T - T^2 saturated.
// ----------------------------------------------------------------------------
module pfsc_butterfly (
  input  logic                 clk,
  input  logic                 capture,
  input  logic [pfsc_pkg::Z_W-1:0] v,
  output logic [pfsc_pkg::Z_W-1:0] upper,
  output logic [pfsc_pkg::Z_W-1:0] lower
);
  import pfsc_pkg::*;

  logic [Z_W-1:0] v_r;
  logic [Z_W-1:0] sq_r;
  logic [2*Z_W-1:0] prod;
  logic [Z_W:0]   diff;

  assign prod = {{Z_W{1'b0}}, v} * {{Z_W{1'b0}}, v};

  always_ff @(posedge clk) begin
    if (capture) begin
      v_r  <= v;
      sq_r <= prod[2*Z_W-1:Z_W];
    end
  end

  // The square never exceeds T, so the difference is never negative.
  assign diff  = {v_r, 1'b0} - {1'b0, sq_r};
  assign upper = diff[Z_W] ? {Z_W{1'b1}} : diff[Z_W-1:0];
  assign lower = sq_r;
endmodule

[src/pfsc_cell.sv]
// ----------------------------------------------------------------------------
// pfsc_cell
// Rank cell: holds one position, counts passing values that outrank it.
// ----------------------------------------------------------------------------
module pfsc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load_en,
  input  pfsc_pkg::pfsc_own_t       own_in,
  output pfsc_pkg::pfsc_own_t       own_out,
  input  pfsc_pkg::pfsc_item_t      item_in,
  output pfsc_pkg::pfsc_item_t      item_out,
  input  logic [pfsc_pkg::IDX_W-1:0] n,
  input  logic [pfsc_pkg::K_W-1:0]   k,
  output logic                      frozen
);
  import pfsc_pkg::*;

  pfsc_own_t        own;
  pfsc_item_t       item;
  logic [IDX_W-1:0] rank;
  logic             beats;

  // A passing value outranks this position when it is larger, or equal and
  // at a lower position.
  assign beats = item_in.valid &&
                 ((item_in.z > own.z) || ((item_in.z == own.z) && (item_in.idx < own.idx)));

  always_ff @(posedge clk) begin
    if (load_en) begin
      own <= own_in;
    end
    if (load_en) begin
      rank <= '0;
    end else if (beats) begin
      rank <= rank + IDX_W'(1);
    end
    item.z   <= item_in.z;
    item.idx <= item_in.idx;
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= item_in.valid;
    end
  end

  assign own_out  = own;
  assign item_out = item;
  assign frozen   = (own.idx < n) && (rank < k);
endmodule

[src/polar_frozen_set_construction.sv]
// ----------------------------------------------------------------------------
// polar_frozen_set_construction
// Polar code construction on an erasure channel: frozen mask from p, n, k.
// ----------------------------------------------------------------------------
// Each request word gives an erasure probability p (unsigned Q0.32), the
// length exponent and the number of positions to freeze. The length exponent
// saturates to 10 and the frozen count to n. The block first builds the
// Bhattacharyya parameters of all n positions in a 1024 x 32 memory: Z[0] is
// set to p and every butterfly reads one entry, squares it through a single
// registered 32 x 32 multiplier and writes 2T - T^2 and T^2 back, n - 1
// butterflies in all. No clearing pass is needed, since every entry is
// written before it is read. The selection then runs on a chain of 64 rank
// cells, one 64-bit result word per pass: the positions of the word are loaded
// into the cells, every Z value streams down the chain, each cell counting
// the values that outrank its own (larger, or equal at a lower position), and
// the chain drains. A cell whose rank is below the frozen count and whose
// position lies below n marks its position frozen. The single memory read
// port is shared by the butterflies and the stream into the chain. Results
// come out as max(1, n/64) words with last_word on the final one; a new
// request is taken once the final word sits in the output register.
// ----------------------------------------------------------------------------
module polar_frozen_set_construction (
  input logic        clk,
  input logic        rst,
  pfsc_in_if.sink    in_ch,
  pfsc_out_if.source out_ch
);
  import pfsc_pkg::*;

  pfsc_state_t state, state_next;

  logic [Z_W-1:0]     p_r;
  logic [LG_W-1:0]    lg_r;
  logic [IDX_W-1:0]   n_r;
  logic [K_W-1:0]     k_r;
  logic [WIDX_W-1:0]  words_m1;
  logic [LG_W-1:0]    s_r;
  logic [IDX_W-1:0]   t_r;
  logic [CELL_AW-1:0] c_r;
  logic [IDX_W-1:0]   j_r;
  logic [WIDX_W-1:0]  w_r;
  logic [DRAIN_W-1:0] drain_r;

  logic [LG_W-1:0]    lg_sat;
  logic [IDX_W-1:0]   n_in;
  logic [K_W-1:0]     k_sat;
  logic [IDX_W-1:0]   words_in;
  logic [IDX_W-1:0]   stride;
  logic [IDX_W-1:0]   half;
  logic [IDX_W-1:0]   t_step;
  logic [IDX_W-1:0]   t_hi;
  logic               stage_end;
  logic [IDX_W-1:0]   load_idx;

  logic [Z_W-1:0]     mem [MEM_DEPTH];
  logic               mem_we;
  logic [MEM_AW-1:0]  mem_wa;
  logic [Z_W-1:0]     mem_wd;
  logic               mem_re;
  logic [MEM_AW-1:0]  mem_ra;
  logic [Z_W-1:0]     rd_data;

  logic               issue_load;
  logic               issue_cmp;
  logic [IDX_W-1:0]   issue_idx;
  logic               head_load;
  logic               head_cmp;
  logic [IDX_W-1:0]   head_idx;

  logic [Z_W-1:0]     bf_upper;
  logic [Z_W-1:0]     bf_lower;

  logic               in_acc;
  logic               out_free;
  logic               emit;

  logic               out_valid;
  logic [WIDX_W-1:0]  out_word_index;
  logic [WORD_W-1:0]  out_mask;
  logic               out_last;

  logic [NCELL-1:0]   frozen;
  pfsc_own_t          own_chain  [NCELL];
  pfsc_item_t         item_chain [NCELL];
  pfsc_own_t          own_head;
  pfsc_item_t         item_head;

  // Request decoding: saturate the length exponent and the frozen count.
  assign lg_sat   = (in_ch.log_length > LG_W'(LOG_CAP)) ? LG_W'(LOG_CAP) : in_ch.log_length;
  assign n_in     = IDX_W'(1) << lg_sat;
  assign k_sat    = (in_ch.frozen_count > K_W'(n_in)) ? K_W'(n_in) : in_ch.frozen_count;
  assign words_in = (n_in >= IDX_W'(NCELL)) ? (n_in >> CELL_AW) : IDX_W'(1);

  // Butterfly addressing: stage s pairs t with t + n/(2u), t stepping by n/u.
  assign stride    = n_r >> s_r;
  assign half      = stride >> 1;
  assign t_step    = t_r + stride;
  assign t_hi      = t_r + half;
  assign stage_end = (t_step >= n_r);

  // Cells are loaded from the top position of the word down, so the first
  // value fed ends up in the last cell.
  assign load_idx = IDX_W'({w_r, ~c_r});

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign emit     = (state == S_DRAIN) && (drain_r == DRAIN_W'(DRAIN_LAST)) && out_free;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_acc) state_next = S_INIT;
      S_INIT:   state_next = (lg_r == '0) ? S_LOAD : S_BF_RD;
      S_BF_RD:  state_next = S_BF_MUL;
      S_BF_MUL: state_next = S_BF_WLO;
      S_BF_WLO: state_next = S_BF_WHI;
      S_BF_WHI: begin
        if (stage_end && (s_r + LG_W'(1) == lg_r)) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_BF_RD;
        end
      end
      S_LOAD:   if (c_r == {CELL_AW{1'b1}}) state_next = S_CMP;
      S_CMP:    if (j_r == n_r - IDX_W'(1)) state_next = S_DRAIN;
      S_DRAIN: begin
        if (emit) begin
          state_next = (w_r == words_m1) ? S_IDLE : S_LOAD;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory and chain controls.
  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = bf_lower;
    mem_re     = 1'b0;
    mem_ra     = '0;
    issue_load = 1'b0;
    issue_cmp  = 1'b0;
    issue_idx  = '0;
    unique case (state)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wd = p_r;
      end
      S_BF_RD: begin
        mem_re = 1'b1;
        mem_ra = t_r[MEM_AW-1:0];
      end
      S_BF_WLO: begin
        mem_we = 1'b1;
        mem_wa = t_r[MEM_AW-1:0];
        mem_wd = bf_upper;
      end
      S_BF_WHI: begin
        mem_we = 1'b1;
        mem_wa = t_hi[MEM_AW-1:0];
        mem_wd = bf_lower;
      end
      S_LOAD: begin
        mem_re     = 1'b1;
        mem_ra     = load_idx[MEM_AW-1:0];
        issue_load = 1'b1;
        issue_idx  = load_idx;
      end
      S_CMP: begin
        mem_re    = 1'b1;
        mem_ra    = j_r[MEM_AW-1:0];
        issue_cmp = 1'b1;
        issue_idx = j_r;
      end
      S_IDLE, S_BF_MUL, S_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  // Reliability memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  pfsc_butterfly u_bf (
    .clk     (clk),
    .capture (state == S_BF_MUL),
    .v       (rd_data),
    .upper   (bf_upper),
    .lower   (bf_lower)
  );

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_load <= 1'b0;
      head_cmp  <= 1'b0;
      c_r       <= '0;
      j_r       <= '0;
      drain_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head_load <= issue_load;
      head_cmp  <= issue_cmp;
      if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end
      if (state == S_IDLE) begin
        c_r     <= '0;
        j_r     <= '0;
        drain_r <= '0;
      end
      if (state == S_LOAD) begin
        c_r <= c_r + CELL_AW'(1);
      end
      if (state == S_CMP) begin
        if (j_r == n_r - IDX_W'(1)) begin
          j_r     <= '0;
          drain_r <= '0;
        end else begin
          j_r <= j_r + IDX_W'(1);
        end
      end
      if ((state == S_DRAIN) && (drain_r != DRAIN_W'(DRAIN_LAST))) begin
        drain_r <= drain_r + DRAIN_W'(1);
      end
    end
  end

  // Request and loop registers.
  always_ff @(posedge clk) begin
    head_idx <= issue_idx;
    if (in_acc) begin
      p_r      <= in_ch.erasure_prob;
      lg_r     <= lg_sat;
      n_r      <= n_in;
      k_r      <= k_sat;
      words_m1 <= WIDX_W'(words_in - IDX_W'(1));
      w_r      <= '0;
    end
    if (state == S_INIT) begin
      s_r <= '0;
      t_r <= '0;
    end
    if (state == S_BF_WHI) begin
      if (stage_end) begin
        s_r <= s_r + LG_W'(1);
        t_r <= '0;
      end else begin
        t_r <= t_step;
      end
    end
    if (emit) begin
      out_word_index <= w_r;
      out_mask       <= frozen;
      out_last       <= (w_r == words_m1);
      w_r            <= w_r + WIDX_W'(1);
    end
  end

  // Rank chain.
  assign own_head        = '{z: rd_data, idx: head_idx};
  assign item_head.valid = head_cmp;
  assign item_head.z     = rd_data;
  assign item_head.idx   = head_idx;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    if (c == 0) begin : g_first
      pfsc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load_en  (head_load),
        .own_in   (own_head),
        .own_out  (own_chain[c]),
        .item_in  (item_head),
        .item_out (item_chain[c]),
        .n        (n_r),
        .k        (k_r),
        .frozen   (frozen[c])
      );
    end else if (c == NCELL - 1) begin : g_last
      pfsc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load_en  (head_load),
        .own_in   (own_chain[c-1]),
        .own_out  (),
        .item_in  (item_chain[c-1]),
        .item_out (),
        .n        (n_r),
        .k        (k_r),
        .frozen   (frozen[c])
      );
    end else begin : g_mid
      pfsc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .load_en  (head_load),
        .own_in   (own_chain[c-1]),
        .own_out  (own_chain[c]),
        .item_in  (item_chain[c-1]),
        .item_out (item_chain[c]),
        .n        (n_r),
        .k        (k_r),
        .frozen   (frozen[c])
      );
    end
  end

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.word_index  = out_word_index;
  assign out_ch.frozen_mask = out_mask;
  assign out_ch.last_word   = out_last;
endmodule

[src/pfsc_checker.sv]
// ----------------------------------------------------------------------------
// pfsc_checker
// Port-level checks of the polar frozen set construction block.
// ----------------------------------------------------------------------------
`include "polar_frozen_set_construction_assert.svh"

module pfsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pfsc_pkg::WIDX_W-1:0]   word_index,
  input logic [pfsc_pkg::WORD_W-1:0]   frozen_mask,
  input logic                          last_word
);
  import pfsc_pkg::*;

  // A held word keeps its contents until taken.
  `PFSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(word_index) && $stable(frozen_mask) && $stable(last_word))

  // A request keeps the block busy for at least the next cycle.
  `PFSC_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)

  // While a request still owes words, no new request is taken.
  `PFSC_ASSERT_IMP(a_busy_mid_req, out_valid && !last_word, !in_ready)

  // The first word of a request is word zero.
  `PFSC_ASSERT_NXT(a_first_word, out_valid && out_ready && last_word, !out_valid || (word_index == '0))
endmodule

bind polar_frozen_set_construction pfsc_checker u_pfsc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .word_index  (out_ch.word_index),
  .frozen_mask (out_ch.frozen_mask),
  .last_word   (out_ch.last_word)
);
